/* hw/rtl/range_mode_count_top_macros.svh */
// assertion macros used by range_mode_count_top
`ifndef RANGE_MODE_COUNT_TOP_MACROS_SVH
`define RANGE_MODE_COUNT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rmc_pkg.sv */
package rmc_pkg;

    // capacities
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DISTINCT = 256;

    // field widths
    localparam int DATA_W = 32;
    localparam int BEST_W = 11;
    localparam int STAT_W = 2;

    // derived widths
    localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ID_W   = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int PCNT_W = $clog2(MAX_POINTS + 1);
    localparam int DCNT_W = $clog2(MAX_DISTINCT + 1);
    localparam int HCNT_W = PCNT_W;

    // point store word: {value id, coordinate}
    localparam int PT_W = DATA_W + ID_W;

    // largest reportable count
    localparam int COUNT_MAX = 2047;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_PTS_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_VAL_FULL = 2'd2;

    // histogram command from the sequencer
    typedef struct packed {
        logic            inc_valid;
        logic [ID_W-1:0] inc_id;
        logic            zero_en;
        logic [ID_W-1:0] zero_id;
        logic            best_clr;
    } t_hist_cmd;

    // saturate a histogram count to the result width
    function automatic logic [BEST_W-1:0] sat_count(input logic [HCNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w > 32'(COUNT_MAX)) begin
            sat_count = BEST_W'(COUNT_MAX);
        end else begin
            sat_count = w[BEST_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/range_mode_count_top.sv */
// a load does a linear search of the value table
// a query does one point store read per cycle, then clears one histogram entry
//   per cycle; a reversed range skips both the scan and the clearing
// throughput: one transaction at a time; the next is taken once the result is registered
// reset: synchronous active low, empties both stores and the value table, no clearing pass
module range_mode_count_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic signed [rmc_pkg::DATA_W-1:0] i_coordinate,
    input  logic signed [rmc_pkg::DATA_W-1:0] i_point_value,
    input  logic signed [rmc_pkg::DATA_W-1:0] i_range_low,
    input  logic signed [rmc_pkg::DATA_W-1:0] i_range_high,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rmc_pkg::BEST_W-1:0]        o_best_count,
    output logic [rmc_pkg::STAT_W-1:0]        o_status
);

    `include "range_mode_count_top_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_QSCAN  = 6'b000100,
        S_QDRAIN = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [rmc_pkg::PCNT_W-1:0] r_pcount, n_pcount;
    logic [rmc_pkg::DCNT_W-1:0] r_dcount, n_dcount;
    logic [rmc_pkg::DCNT_W-1:0] r_k, n_k;
    logic [rmc_pkg::PCNT_W-1:0] r_pk, n_pk;
    logic                       r_cmp_valid, n_cmp_valid;
    logic [rmc_pkg::ID_W-1:0]   r_cmp_k, n_cmp_k;
    logic                       r_s1_valid, n_s1_valid;
    logic [rmc_pkg::DATA_W-1:0] r_coord, n_coord;
    logic [rmc_pkg::DATA_W-1:0] r_val, n_val;
    logic signed [rmc_pkg::DATA_W-1:0] r_lo, n_lo;
    logic signed [rmc_pkg::DATA_W-1:0] r_hi, n_hi;
    logic                       r_is_query, n_is_query;
    logic [rmc_pkg::STAT_W-1:0] r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic [rmc_pkg::BEST_W-1:0] r_best_out, n_best_out;
    logic [rmc_pkg::STAT_W-1:0] r_stat_out, n_stat_out;

    logic                       in_acc;
    logic                       hit;
    logic                       k_below;
    logic                       pk_below;
    logic                       in_range;
    logic signed [rmc_pkg::DATA_W-1:0] pt_coord;
    logic [rmc_pkg::ID_W-1:0]   pt_id;

    logic                       pt_we, pt_re;
    logic [rmc_pkg::PIDX_W-1:0] pt_waddr, pt_raddr;
    logic [rmc_pkg::PT_W-1:0]   pt_wdata, pt_rdata;
    logic                       vt_we, vt_re;
    logic [rmc_pkg::ID_W-1:0]   vt_waddr, vt_raddr;
    logic [rmc_pkg::DATA_W-1:0] vt_rdata;
    rmc_pkg::t_hist_cmd         hcmd;
    logic [rmc_pkg::HCNT_W-1:0] hist_best;
    logic                       hist_busy;

    // point store: {value id, coordinate}
    rmc_ram #(
        .DEPTH (rmc_pkg::MAX_POINTS),
        .WIDTH (rmc_pkg::PT_W)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // distinct value table
    rmc_ram #(
        .DEPTH (rmc_pkg::MAX_DISTINCT),
        .WIDTH (rmc_pkg::DATA_W)
    ) u_vt_ram (
        .i_clk   (i_clk),
        .i_we    (vt_we),
        .i_waddr (vt_waddr),
        .i_wdata (r_val),
        .i_re    (vt_re),
        .i_raddr (vt_raddr),
        .o_rdata (vt_rdata)
    );

    // histogram with read-modify-write
    rmc_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (hcmd),
        .o_best  (hist_best),
        .o_busy  (hist_busy)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign k_below  = (r_k < r_dcount);
    assign pk_below = (r_pk < r_pcount);
    assign hit      = r_cmp_valid && (vt_rdata == r_val);
    assign pt_coord = $signed(pt_rdata[rmc_pkg::DATA_W-1:0]);
    assign pt_id    = pt_rdata[rmc_pkg::PT_W-1:rmc_pkg::DATA_W];
    assign in_range = (pt_coord >= r_lo) && (pt_coord <= r_hi);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pcount    = r_pcount;
        n_dcount    = r_dcount;
        n_k         = r_k;
        n_pk        = r_pk;
        n_cmp_valid = 1'b0;
        n_cmp_k     = r_cmp_k;
        n_s1_valid  = 1'b0;
        n_coord     = r_coord;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_is_query  = r_is_query;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_best_out  = r_best_out;
        n_stat_out  = r_stat_out;

        pt_we    = 1'b0;
        pt_waddr = r_pcount[rmc_pkg::PIDX_W-1:0];
        pt_wdata = {r_cmp_k, r_coord};
        pt_re    = 1'b0;
        pt_raddr = r_pk[rmc_pkg::PIDX_W-1:0];
        vt_we    = 1'b0;
        vt_waddr = r_dcount[rmc_pkg::ID_W-1:0];
        vt_re    = 1'b0;
        vt_raddr = r_k[rmc_pkg::ID_W-1:0];

        hcmd.inc_valid = r_s1_valid && in_range;
        hcmd.inc_id    = pt_id;
        hcmd.zero_en   = 1'b0;
        hcmd.zero_id   = r_k[rmc_pkg::ID_W-1:0];
        hcmd.best_clr  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_is_query = (i_opcode == rmc_pkg::OP_QUERY);
                    n_status   = rmc_pkg::ST_OK;
                    if (i_opcode == rmc_pkg::OP_LOAD) begin
                        n_coord = i_coordinate;
                        n_val   = i_point_value;
                        n_k     = '0;
                        if (r_pcount == rmc_pkg::PCNT_W'(rmc_pkg::MAX_POINTS)) begin
                            n_status = rmc_pkg::ST_PTS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end else begin
                        n_lo          = i_range_low;
                        n_hi          = i_range_high;
                        n_pk          = '0;
                        hcmd.best_clr = 1'b1;
                        if (i_range_low > i_range_high) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_QSCAN;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    // value already known
                    pt_we    = 1'b1;
                    n_pcount = r_pcount + rmc_pkg::PCNT_W'(1);
                    n_state  = S_DONE;
                end else if (!r_cmp_valid && !k_below) begin
                    // value is new
                    if (r_dcount == rmc_pkg::DCNT_W'(rmc_pkg::MAX_DISTINCT)) begin
                        n_status = rmc_pkg::ST_VAL_FULL;
                    end else begin
                        vt_we        = 1'b1;
                        hcmd.zero_en = 1'b1;
                        hcmd.zero_id = r_dcount[rmc_pkg::ID_W-1:0];
                        pt_we        = 1'b1;
                        pt_wdata     = {r_dcount[rmc_pkg::ID_W-1:0], r_coord};
                        n_pcount     = r_pcount + rmc_pkg::PCNT_W'(1);
                        n_dcount     = r_dcount + rmc_pkg::DCNT_W'(1);
                    end
                    n_state = S_DONE;
                end else begin
                    // issue the next table read
                    vt_re       = k_below;
                    n_cmp_valid = k_below;
                    n_cmp_k     = r_k[rmc_pkg::ID_W-1:0];
                    if (k_below) begin
                        n_k = r_k + rmc_pkg::DCNT_W'(1);
                    end
                end
            end
            S_QSCAN: begin
                pt_re      = pk_below;
                n_s1_valid = pk_below;
                if (pk_below) begin
                    n_pk = r_pk + rmc_pkg::PCNT_W'(1);
                end else begin
                    n_state = S_QDRAIN;
                end
            end
            S_QDRAIN: begin
                if (!r_s1_valid && !hist_busy) begin
                    n_k     = '0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (k_below) begin
                    hcmd.zero_en = 1'b1;
                    n_k          = r_k + rmc_pkg::DCNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_best_out  = r_is_query ? rmc_pkg::sat_count(hist_best) : '0;
                    n_stat_out  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pcount    <= '0;
            r_dcount    <= '0;
            r_cmp_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pcount    <= n_pcount;
            r_dcount    <= n_dcount;
            r_cmp_valid <= n_cmp_valid;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_pk       <= n_pk;
        r_cmp_k    <= n_cmp_k;
        r_coord    <= n_coord;
        r_val      <= n_val;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_is_query <= n_is_query;
        r_status   <= n_status;
        r_best_out <= n_best_out;
        r_stat_out <= n_stat_out;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_best_count = r_best_out;
    assign o_status     = r_stat_out;

    // checks
    `RMC_ASSERT_NOW(a_pcount_cap, 1'b1,
        r_pcount <= rmc_pkg::PCNT_W'(rmc_pkg::MAX_POINTS), "point count beyond capacity")
    `RMC_ASSERT_NOW(a_dcount_cap, 1'b1,
        r_dcount <= rmc_pkg::DCNT_W'(rmc_pkg::MAX_DISTINCT), "distinct count beyond capacity")
    `RMC_ASSERT_NOW(a_hist_idle_on_accept, i_in_valid && !o_in_stall,
        !hist_busy && !r_s1_valid, "transaction taken while histogram pipeline busy")
    `RMC_ASSERT_NEXT(a_result_loaded, (r_state == S_DONE) && (!r_out_valid || !i_out_stall),
        o_out_valid && (r_state == S_IDLE), "finished result not registered")

endmodule

/* hw/rtl/rmc_ram.sv */
module rmc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rmc_hist.sv */
module rmc_hist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rmc_pkg::t_hist_cmd        i_cmd,
    output logic [rmc_pkg::HCNT_W-1:0] o_best,
    output logic                      o_busy
);

    logic [rmc_pkg::HCNT_W-1:0] mem [rmc_pkg::MAX_DISTINCT];
    logic [rmc_pkg::HCNT_W-1:0] r_rdata;
    logic                       r_s2_valid;
    logic [rmc_pkg::ID_W-1:0]   r_s2_id;
    logic                       r_wr_valid;
    logic [rmc_pkg::ID_W-1:0]   r_wr_id;
    logic [rmc_pkg::HCNT_W-1:0] r_wr_data;
    logic [rmc_pkg::HCNT_W-1:0] r_best;
    logic [rmc_pkg::HCNT_W-1:0] cur;
    logic [rmc_pkg::HCNT_W-1:0] inc;

    // read stage: fetch the count of the incoming id
    always_ff @(posedge i_clk) begin
        if (i_cmd.inc_valid) begin
            r_rdata <= mem[i_cmd.inc_id];
        end
    end

    // forward the write of the previous cycle on a back-to-back hit
    assign cur = (r_wr_valid && (r_wr_id == r_s2_id)) ? r_wr_data : r_rdata;
    assign inc = cur + rmc_pkg::HCNT_W'(1);

    // write back the increment, or zero an entry
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            mem[r_s2_id] <= inc;
        end else if (i_cmd.zero_en) begin
            mem[i_cmd.zero_id] <= '0;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_wr_valid <= 1'b0;
            r_best     <= '0;
        end else begin
            r_s2_valid <= i_cmd.inc_valid;
            r_wr_valid <= r_s2_valid;
            if (i_cmd.best_clr) begin
                r_best <= '0;
            end else if (r_s2_valid && (inc > r_best)) begin
                r_best <= inc;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s2_id   <= i_cmd.inc_id;
        r_wr_id   <= r_s2_id;
        r_wr_data <= inc;
    end

    assign o_best = r_best;
    assign o_busy = r_s2_valid;

endmodule
